/* hdl/sha1d_pkg.sv */
// sha1d_pkg: shared types and constants for the sha1 digest block
// chaining initial values, round constants and the sequencer state type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sha1d_pkg;

    localparam logic [31:0] H0_INIT = 32'h6745_2301;
    localparam logic [31:0] H1_INIT = 32'hEFCD_AB89;
    localparam logic [31:0] H2_INIT = 32'h98BA_DCFE;
    localparam logic [31:0] H3_INIT = 32'h1032_5476;
    localparam logic [31:0] H4_INIT = 32'hC3D2_E1F0;

    localparam logic [31:0] K_00_19 = 32'h5A82_7999;
    localparam logic [31:0] K_20_39 = 32'h6ED9_EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1B_BCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62_C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [2:0] LAST_WORD  = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        return {x[30:0], x[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] x);
        return {x[1:0], x[31:2]};
    endfunction

endpackage

`default_nettype wire

/* hdl/sha1_digest_top.sv */
// sha1_digest_top: byte-serial sha-1 digest with a shared single-round unit
// the 512-bit block register doubles as the 16-word schedule window
// depends on sha1d_pkg
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | i_valid / o_stall  | i_data_byte, i_byte_valid, i_last
//   output   | o_valid / i_stall  | o_digest_word, o_word_index, o_final_word
//
// a request is taken while idle; every 64th byte starts a compression (the rounds
// through the one round unit, then the chain add), during which input is stalled
// the finish shifts one padding byte per cycle into the block register, runs
// one or two compressions, then offers the five digest words one per cycle while i_stall is low
// o_stall is high whenever the sequencer is away from idle
// reset is synchronous, active low, and restores the initial chaining values
`timescale 1ns / 1ps
`default_nettype none

module sha1_digest_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_byte_valid,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_final_word
);
    import sha1d_pkg::*;

    t_state        r_state, n_state;
    logic [5:0]    r_fill, n_fill;
    logic [63:0]   r_len, n_len;
    logic [6:0]    r_round, n_round;
    logic [2:0]    r_widx, n_widx;
    logic          r_finish, n_finish;
    logic          r_pad_first, n_pad_first;
    logic          r_len_ok, n_len_ok;
    logic [31:0]   r_h0, r_h1, r_h2, r_h3, r_h4;
    logic [31:0]   n_h0, n_h1, n_h2, n_h3, n_h4;

    logic [511:0]  r_blk, n_blk;
    logic [31:0]   r_a, r_b, r_c, r_d, r_e;
    logic [31:0]   n_a, n_b, n_c, n_d, n_e;

    logic [31:0]   w_cur, w_new, f_val, k_val, t_val;
    logic          shift_en;
    logic [7:0]    shift_byte;
    logic          start_cmp;

    // round unit
    always_comb begin
        w_cur = r_blk[511:480];
        w_new = rotl1(r_blk[95:64] ^ r_blk[255:224] ^ r_blk[447:416] ^ r_blk[511:480]);
        if (r_round < 7'd20) begin
            f_val = (r_b & r_c) | (~r_b & r_d);
            k_val = K_00_19;
        end else if (r_round < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_20_39;
        end else if (r_round < 7'd60) begin
            f_val = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k_val = K_40_59;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_60_79;
        end
        t_val = rotl5(r_a) + f_val + r_e + k_val + w_cur;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_len       = r_len;
        n_round     = r_round;
        n_widx      = r_widx;
        n_finish    = r_finish;
        n_pad_first = r_pad_first;
        n_len_ok    = r_len_ok;
        n_h0 = r_h0; n_h1 = r_h1; n_h2 = r_h2; n_h3 = r_h3; n_h4 = r_h4;
        shift_en    = 1'b0;
        shift_byte  = 8'h00;
        start_cmp   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_byte_valid) begin
                        shift_en   = 1'b1;
                        shift_byte = i_data_byte;
                        n_fill     = r_fill + 6'd1;
                        n_len      = r_len + 64'd8;
                    end
                    if (i_last) begin
                        n_finish    = 1'b1;
                        n_pad_first = 1'b1;
                    end
                    if (i_byte_valid && r_fill == LAST_BYTE) begin
                        start_cmp = 1'b1;
                        n_state   = ST_ROUND;
                    end else if (i_last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                shift_en = 1'b1;
                n_fill   = r_fill + 6'd1;
                if (r_pad_first) begin
                    shift_byte  = PAD_MARK;
                    n_pad_first = 1'b0;
                    n_len_ok    = (r_fill < LEN_START);
                end else if (r_len_ok && r_fill >= LEN_START) begin
                    shift_byte = r_len[63:56];
                    n_len      = {r_len[55:0], 8'h00};
                end
                if (r_fill == LAST_BYTE) begin
                    start_cmp = 1'b1;
                    n_state   = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_round = r_round + 7'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_h0 = r_h0 + r_a;
                n_h1 = r_h1 + r_b;
                n_h2 = r_h2 + r_c;
                n_h3 = r_h3 + r_d;
                n_h4 = r_h4 + r_e;
                if (!r_finish) begin
                    n_state = ST_IDLE;
                end else if (r_pad_first) begin
                    n_state = ST_PAD;
                end else if (r_len_ok) begin
                    n_widx  = 3'd0;
                    n_state = ST_OUT;
                end else begin
                    // length goes into a second padding block
                    n_len_ok = 1'b1;
                    n_state  = ST_PAD;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    if (r_widx == LAST_WORD) begin
                        n_h0 = H0_INIT; n_h1 = H1_INIT; n_h2 = H2_INIT;
                        n_h3 = H3_INIT; n_h4 = H4_INIT;
                        n_fill      = 6'd0;
                        n_len       = 64'd0;
                        n_finish    = 1'b0;
                        n_pad_first = 1'b0;
                        n_len_ok    = 1'b0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_widx = r_widx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (start_cmp) begin
            n_round = 7'd0;
        end
    end

    // datapath next values
    always_comb begin
        n_blk = r_blk;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e;
        if (shift_en) begin
            n_blk = {r_blk[503:0], shift_byte};
        end else if (r_state == ST_ROUND) begin
            n_blk = {r_blk[479:0], w_new};
        end
        if (start_cmp) begin
            n_a = r_h0; n_b = r_h1; n_c = r_h2; n_d = r_h3; n_e = r_h4;
        end else if (r_state == ST_ROUND) begin
            n_e = r_d;
            n_d = r_c;
            n_c = rotl30(r_b);
            n_b = r_a;
            n_a = t_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= 6'd0;
            r_len       <= 64'd0;
            r_round     <= 7'd0;
            r_widx      <= 3'd0;
            r_finish    <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_h0        <= H0_INIT;
            r_h1        <= H1_INIT;
            r_h2        <= H2_INIT;
            r_h3        <= H3_INIT;
            r_h4        <= H4_INIT;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_len       <= n_len;
            r_round     <= n_round;
            r_widx      <= n_widx;
            r_finish    <= n_finish;
            r_pad_first <= n_pad_first;
            r_len_ok    <= n_len_ok;
            r_h0        <= n_h0;
            r_h1        <= n_h1;
            r_h2        <= n_h2;
            r_h3        <= n_h3;
            r_h4        <= n_h4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_a   <= n_a;
        r_b   <= n_b;
        r_c   <= n_c;
        r_d   <= n_d;
        r_e   <= n_e;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);

    always_comb begin
        case (r_widx)
            3'd0:    o_digest_word = r_h0;
            3'd1:    o_digest_word = r_h1;
            3'd2:    o_digest_word = r_h2;
            3'd3:    o_digest_word = r_h3;
            default: o_digest_word = r_h4;
        endcase
    end

    assign o_word_index = r_widx;
    assign o_final_word = (r_widx == LAST_WORD);

endmodule

`default_nettype wire
